/* rtl/assert_macros.svh */
// assertion macros shared by the rtl files
// no dependencies; bodies are empty when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/mdus_pkg.sv */
// types, constants and command/status structs of the multidrop uart slave
// no dependencies
package mdus_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int CNT_W       = $clog2(BLOCK_BYTES + 1);
    localparam int STORE_DEPTH = 16;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int PADDR_W     = 4;

    // op codes
    localparam logic [1:0] OP_FRAME = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // register indexes
    localparam logic [1:0] REG_SLAVE_ADDR = 2'd0;
    localparam logic [1:0] REG_RX_READY   = 2'd1;
    localparam logic [1:0] REG_TX_READY   = 2'd2;

    // protocol bytes
    localparam logic [7:0] CMD_RECEIVE  = 8'h01;
    localparam logic [7:0] CMD_SEND     = 8'h02;
    localparam logic [7:0] ST_ERROR     = 8'h80;
    localparam logic [7:0] ST_GOOD      = 8'h00;
    localparam logic [7:0] ST_BAD       = 8'hFF;
    localparam logic [7:0] ST_NOT_READY = 8'h00;

    // output byte select
    localparam logic [3:0] OSEL_ADDR    = 4'd0;
    localparam logic [3:0] OSEL_RX_STAT = 4'd1;
    localparam logic [3:0] OSEL_TX_STAT = 4'd2;
    localparam logic [3:0] OSEL_ERROR   = 4'd3;
    localparam logic [3:0] OSEL_GOOD    = 4'd4;
    localparam logic [3:0] OSEL_BAD     = 4'd5;
    localparam logic [3:0] OSEL_RDATA   = 4'd6;
    localparam logic [3:0] OSEL_TDATA   = 4'd7;
    localparam logic [3:0] OSEL_TSUM    = 4'd8;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] frame_byte;
        logic       ninth_bit;
        logic [3:0] entry_index;
        logic [7:0] entry_value;
    } t_in_item;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic       load_out;
        logic [3:0] osel;
        logic       tx_wr;
        logic       rx_rd;
        logic       rx_wr;
        logic       cnt_clr;
        logic       rx_rdy_clr;
        logic       tx_rdy_clr;
        logic       tx_start;
        logic       tx_step;
    } t_cmd;

    typedef struct packed {
        logic addr_match;
        logic sum_match;
        logic cnt_last;
        logic tx_last;
        logic out_free;
    } t_sts;

endpackage

/* rtl/mdus_ram.sv */
// generic simple dual-port ram with registered read
// no dependencies
module mdus_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/mdus_ctrl.sv */
// controller: protocol phase and per-transaction sequencer
// depends on mdus_pkg and assert_macros.svh
`include "assert_macros.svh"
module mdus_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  mdus_pkg::t_in_item i_in_item,
    input  mdus_pkg::t_sts    i_sts,
    output logic              o_in_ready,
    output mdus_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_CMD     = 3'd1;
    localparam logic [2:0] PH_RX_GO   = 3'd2;
    localparam logic [2:0] PH_RX_DATA = 3'd3;
    localparam logic [2:0] PH_RX_SUM  = 3'd4;
    localparam logic [2:0] PH_TX_GO   = 3'd5;
    localparam logic [2:0] PH_TX_ACK  = 3'd6;

    localparam logic [1:0] SQ_IDLE    = 2'd0;
    localparam logic [1:0] SQ_RD      = 2'd1;
    localparam logic [1:0] SQ_TX_DATA = 2'd2;
    localparam logic [1:0] SQ_TX_SUM  = 2'd3;

    logic [2:0]     r_phase, n_phase;
    logic [1:0]     r_seq, n_seq;
    logic           in_ready;
    logic           accept;
    mdus_pkg::t_cmd cmd;

    assign in_ready = (r_seq == SQ_IDLE) && i_sts.out_free;
    assign accept   = in_ready && i_in_valid;

    always_comb begin
        cmd     = '0;
        n_phase = r_phase;
        n_seq   = r_seq;
        case (r_seq)
            SQ_IDLE: begin
                if (accept) begin
                    case (i_in_item.op)
                        mdus_pkg::OP_LOAD: begin
                            cmd.tx_wr = 1'b1;
                        end
                        mdus_pkg::OP_READ: begin
                            cmd.rx_rd = 1'b1;
                            n_seq     = SQ_RD;
                        end
                        mdus_pkg::OP_FRAME: begin
                            case (r_phase)
                                PH_CMD: begin
                                    if (i_in_item.ninth_bit) begin
                                        n_phase = PH_IDLE;
                                    end else if (i_in_item.frame_byte == mdus_pkg::CMD_RECEIVE) begin
                                        n_phase      = PH_RX_GO;
                                        cmd.load_out = 1'b1;
                                        cmd.osel     = mdus_pkg::OSEL_RX_STAT;
                                    end else if (i_in_item.frame_byte == mdus_pkg::CMD_SEND) begin
                                        n_phase      = PH_TX_GO;
                                        cmd.load_out = 1'b1;
                                        cmd.osel     = mdus_pkg::OSEL_TX_STAT;
                                    end else begin
                                        n_phase      = PH_IDLE;
                                        cmd.load_out = 1'b1;
                                        cmd.osel     = mdus_pkg::OSEL_ERROR;
                                    end
                                end
                                PH_RX_GO: begin
                                    if (i_in_item.ninth_bit) begin
                                        n_phase = PH_IDLE;
                                    end else begin
                                        n_phase        = PH_RX_DATA;
                                        cmd.rx_rdy_clr = 1'b1;
                                        cmd.cnt_clr    = 1'b1;
                                    end
                                end
                                PH_RX_DATA: begin
                                    cmd.rx_wr = 1'b1;
                                    if (i_sts.cnt_last) begin
                                        n_phase = PH_RX_SUM;
                                    end
                                end
                                PH_RX_SUM: begin
                                    cmd.load_out = 1'b1;
                                    if (i_sts.sum_match) begin
                                        n_phase  = PH_IDLE;
                                        cmd.osel = mdus_pkg::OSEL_GOOD;
                                    end else begin
                                        // checksum bad: master resends the block
                                        n_phase     = PH_RX_DATA;
                                        cmd.cnt_clr = 1'b1;
                                        cmd.osel    = mdus_pkg::OSEL_BAD;
                                    end
                                end
                                PH_TX_GO: begin
                                    if (i_in_item.ninth_bit) begin
                                        n_phase = PH_IDLE;
                                    end else begin
                                        n_phase        = PH_TX_ACK;
                                        cmd.tx_rdy_clr = 1'b1;
                                        cmd.tx_start   = 1'b1;
                                        n_seq          = SQ_TX_DATA;
                                    end
                                end
                                PH_TX_ACK: begin
                                    if (i_in_item.frame_byte == mdus_pkg::ST_GOOD) begin
                                        n_phase = PH_IDLE;
                                    end else begin
                                        cmd.tx_start = 1'b1;
                                        n_seq        = SQ_TX_DATA;
                                    end
                                end
                                default: begin
                                    n_phase = PH_IDLE;
                                    if (i_in_item.ninth_bit && i_sts.addr_match) begin
                                        n_phase      = PH_CMD;
                                        cmd.load_out = 1'b1;
                                        cmd.osel     = mdus_pkg::OSEL_ADDR;
                                    end
                                end
                            endcase
                        end
                        default: ;
                    endcase
                end
            end
            SQ_RD: begin
                // output slot was freed when the read was accepted
                cmd.load_out = 1'b1;
                cmd.osel     = mdus_pkg::OSEL_RDATA;
                n_seq        = SQ_IDLE;
            end
            SQ_TX_DATA: begin
                if (i_sts.out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.osel     = mdus_pkg::OSEL_TDATA;
                    cmd.tx_step  = 1'b1;
                    if (i_sts.tx_last) begin
                        n_seq = SQ_TX_SUM;
                    end
                end
            end
            SQ_TX_SUM: begin
                if (i_sts.out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.osel     = mdus_pkg::OSEL_TSUM;
                    n_seq        = SQ_IDLE;
                end
            end
            default: begin
                n_seq = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_seq   <= SQ_IDLE;
        end else begin
            r_phase <= n_phase;
            r_seq   <= n_seq;
        end
    end

    assign o_in_ready = in_ready;
    assign o_cmd      = cmd;

    `ASSERT_IMPL(a_load_needs_slot, i_clk, i_rst_n, cmd.load_out, i_sts.out_free)
    `ASSERT_IMPL(a_burst_in_ack_phase, i_clk, i_rst_n,
        (r_seq == SQ_TX_DATA) || (r_seq == SQ_TX_SUM), r_phase == PH_TX_ACK)
    `ASSERT_NEXT(a_sum_after_data, i_clk, i_rst_n,
        (r_seq == SQ_TX_DATA) && cmd.tx_step && i_sts.tx_last, r_seq == SQ_TX_SUM)

endmodule

/* rtl/mdus_dp.sv */
// datapath: config registers, counters, checksums, stores and output register
// depends on mdus_pkg, mdus_ram and assert_macros.svh
`include "assert_macros.svh"
module mdus_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mdus_pkg::t_in_item             i_in_item,
    input  mdus_pkg::t_cmd                 i_cmd,
    input  logic                           i_out_stall,
    input  logic                           i_cfg_wr,
    input  logic [mdus_pkg::PADDR_W-1:0]   i_cfg_addr,
    input  logic [31:0]                    i_cfg_data,
    output logic [31:0]                    o_cfg_rdata,
    output mdus_pkg::t_sts                 o_sts,
    output logic                           o_out_valid,
    output mdus_pkg::t_out_item            o_out_item
);

    logic [7:0]                    r_slave_addr;
    logic                          r_rx_ready;
    logic                          r_tx_ready;
    logic [mdus_pkg::CNT_W-1:0]    r_byte_count;
    logic [7:0]                    r_rx_sum;
    logic [mdus_pkg::CNT_W-1:0]    r_tx_cnt;
    logic [7:0]                    r_tx_sum;
    logic                          r_out_valid;
    mdus_pkg::t_out_item           r_out_item;
    mdus_pkg::t_out_item           n_out_item;
    logic [1:0]                    cfg_idx;
    logic [7:0]                    rx_rd_data;
    logic [7:0]                    tx_rd_data;
    logic [mdus_pkg::STORE_AW-1:0] tx_rd_addr;
    logic [mdus_pkg::CNT_W-1:0]    tx_cnt_inc;
    logic                          out_free;

    assign cfg_idx    = i_cfg_addr[mdus_pkg::PADDR_W-1:2];
    assign out_free   = !r_out_valid || !i_out_stall;
    assign tx_cnt_inc = mdus_pkg::CNT_W'(r_tx_cnt + 1'b1);
    assign tx_rd_addr = i_cmd.tx_start ? '0 : mdus_pkg::STORE_AW'(tx_cnt_inc);

    mdus_ram #(.WIDTH(8), .DEPTH(mdus_pkg::STORE_DEPTH)) u_rx_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.rx_wr),
        .i_wr_addr (mdus_pkg::STORE_AW'(r_byte_count)),
        .i_wr_data (i_in_item.frame_byte),
        .i_rd_en   (i_cmd.rx_rd),
        .i_rd_addr (i_in_item.entry_index),
        .o_rd_data (rx_rd_data)
    );

    mdus_ram #(.WIDTH(8), .DEPTH(mdus_pkg::STORE_DEPTH)) u_tx_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.tx_wr),
        .i_wr_addr (i_in_item.entry_index),
        .i_wr_data (i_in_item.entry_value),
        .i_rd_en   (i_cmd.tx_start || i_cmd.tx_step),
        .i_rd_addr (tx_rd_addr),
        .o_rd_data (tx_rd_data)
    );

    always_comb begin
        n_out_item      = '0;
        n_out_item.kind = (i_cmd.osel == mdus_pkg::OSEL_RDATA);
        n_out_item.last = (i_cmd.osel != mdus_pkg::OSEL_TDATA);
        case (i_cmd.osel)
            mdus_pkg::OSEL_ADDR:    n_out_item.data_byte = r_slave_addr;
            mdus_pkg::OSEL_RX_STAT: n_out_item.data_byte = r_rx_ready ? mdus_pkg::CMD_RECEIVE
                                                                      : mdus_pkg::ST_NOT_READY;
            mdus_pkg::OSEL_TX_STAT: n_out_item.data_byte = r_tx_ready ? mdus_pkg::CMD_SEND
                                                                      : mdus_pkg::ST_NOT_READY;
            mdus_pkg::OSEL_ERROR:   n_out_item.data_byte = mdus_pkg::ST_ERROR;
            mdus_pkg::OSEL_GOOD:    n_out_item.data_byte = mdus_pkg::ST_GOOD;
            mdus_pkg::OSEL_BAD:     n_out_item.data_byte = mdus_pkg::ST_BAD;
            mdus_pkg::OSEL_RDATA:   n_out_item.data_byte = rx_rd_data;
            mdus_pkg::OSEL_TDATA:   n_out_item.data_byte = tx_rd_data;
            mdus_pkg::OSEL_TSUM:    n_out_item.data_byte = r_tx_sum;
            default:                n_out_item.data_byte = 8'h00;
        endcase
    end

    always_comb begin
        case (cfg_idx)
            mdus_pkg::REG_SLAVE_ADDR: o_cfg_rdata = {24'd0, r_slave_addr};
            mdus_pkg::REG_RX_READY:   o_cfg_rdata = {31'd0, r_rx_ready};
            mdus_pkg::REG_TX_READY:   o_cfg_rdata = {31'd0, r_tx_ready};
            default:                  o_cfg_rdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr <= 8'h02;
            r_rx_ready   <= 1'b1;
            r_tx_ready   <= 1'b1;
            r_byte_count <= '0;
            r_rx_sum     <= 8'h00;
            r_tx_cnt     <= '0;
            r_tx_sum     <= 8'h00;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr && (cfg_idx == mdus_pkg::REG_SLAVE_ADDR)) begin
                r_slave_addr <= i_cfg_data[7:0];
            end
            if (i_cfg_wr && (cfg_idx == mdus_pkg::REG_RX_READY)) begin
                r_rx_ready <= i_cfg_data[0];
            end else if (i_cmd.rx_rdy_clr) begin
                r_rx_ready <= 1'b0;
            end
            if (i_cfg_wr && (cfg_idx == mdus_pkg::REG_TX_READY)) begin
                r_tx_ready <= i_cfg_data[0];
            end else if (i_cmd.tx_rdy_clr) begin
                r_tx_ready <= 1'b0;
            end
            if (i_cmd.cnt_clr) begin
                r_byte_count <= '0;
                r_rx_sum     <= 8'h00;
            end else if (i_cmd.rx_wr) begin
                r_byte_count <= mdus_pkg::CNT_W'(r_byte_count + 1'b1);
                r_rx_sum     <= r_rx_sum + i_in_item.frame_byte;
            end
            if (i_cmd.tx_start) begin
                r_tx_cnt <= '0;
                r_tx_sum <= 8'h00;
            end else if (i_cmd.tx_step) begin
                r_tx_cnt <= tx_cnt_inc;
                r_tx_sum <= r_tx_sum + tx_rd_data;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_sts.addr_match = (i_in_item.frame_byte == r_slave_addr);
    assign o_sts.sum_match  = (i_in_item.frame_byte == r_rx_sum);
    assign o_sts.cnt_last   = (r_byte_count == mdus_pkg::CNT_W'(mdus_pkg::BLOCK_BYTES - 1));
    assign o_sts.tx_last    = (r_tx_cnt == mdus_pkg::CNT_W'(mdus_pkg::BLOCK_BYTES - 1));
    assign o_sts.out_free   = out_free;
    assign o_out_valid      = r_out_valid;
    assign o_out_item       = r_out_item;

    `ASSERT_IMPL(a_rx_count_range, i_clk, i_rst_n, i_cmd.rx_wr,
        r_byte_count < mdus_pkg::CNT_W'(mdus_pkg::BLOCK_BYTES))
    `ASSERT_IMPL(a_tx_count_range, i_clk, i_rst_n, i_cmd.tx_step,
        r_tx_cnt < mdus_pkg::CNT_W'(mdus_pkg::BLOCK_BYTES))

endmodule

/* rtl/multidrop_uart_slave_block_transfer.sv */
// top level of the multidrop uart slave with block transfer
// depends on mdus_pkg, mdus_ctrl, mdus_dp, mdus_ram
//
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_stall   i_in_item  (mdus_pkg::t_in_item)
//  out      output     o_out_valid / i_out_stall o_out_item (mdus_pkg::t_out_item)
//  cfg      input      apb psel/penable/pwrite   paddr, pwdata, prdata
//
// one transaction at a time; status replies go straight to the output register,
// a store read first passes the registered store read port and the read state
// a block send reads each data byte from the tx store, then sends the checksum
// output stalls hold the burst; a result held by the receiver also stalls the input
// synchronous active-low reset; stores are not cleared and need no reset pass
module multidrop_uart_slave_block_transfer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  mdus_pkg::t_in_item           i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output mdus_pkg::t_out_item          o_out_item,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mdus_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    mdus_pkg::t_cmd cmd;
    mdus_pkg::t_sts sts;
    logic           in_ready;
    logic           cfg_wr;

    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite;
    assign o_in_stall = !in_ready;

    mdus_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .i_sts      (sts),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    mdus_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .i_cfg_wr    (cfg_wr),
        .i_cfg_addr  (paddr),
        .i_cfg_data  (pwdata),
        .o_cfg_rdata (prdata),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// self-checking testbench of multidrop_uart_slave_block_transfer: frames and store ops in,
// replies predicted in place and checked in order; depends on mdus_pkg and the rtl top
module testbench;

    localparam logic [7:0] RESET_SLAVE_ADDR = 8'h02;
    localparam logic [7:0] ACK_DONE         = 8'h00;
    localparam logic [1:0] OP_UNUSED        = 2'd3;
    localparam int         SETTLE_CYCLES    = 40;
    localparam int         PHASES           = 6;
    localparam int         ITEM_GOAL        = 420;

    typedef enum logic [2:0] {
        LS_IDLE, LS_CMD, LS_RX_GO, LS_RX_DATA, LS_RX_SUM, LS_TX_GO, LS_TX_ACK
    } t_link_state;

    typedef enum {SEQ_RECEIVE, SEQ_SEND, SEQ_NOISE} t_seq_kind;

    typedef struct {
        mdus_pkg::t_in_item item;
        bit                 typed;
        logic [7:0]         reply;
    } t_row;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    mdus_pkg::t_in_item           in_item;
    logic                         out_valid;
    logic                         out_stall;
    mdus_pkg::t_out_item          out_item;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [mdus_pkg::PADDR_W-1:0] paddr;
    logic [31:0]                  pwdata;
    logic [31:0]                  prdata;
    logic                         pready;

    // slave state as predicted
    logic [7:0]                       cfg_addr;
    logic                             cfg_rx_rdy;
    logic                             cfg_tx_rdy;
    t_link_state                      link;
    logic [4:0]                       blk_count;
    logic [7:0]                       blk_sum;
    logic [7:0]                       rx_store [mdus_pkg::STORE_DEPTH];
    logic [7:0]                       tx_store [mdus_pkg::STORE_DEPTH];
    logic [mdus_pkg::STORE_DEPTH-1:0] rx_written;

    mdus_pkg::t_out_item reply_q[$];
    mdus_pkg::t_out_item step_q[$];
    t_row                plan[$];
    int                  errors = 0;
    int                  items_sent = 0;
    int                  in_idle_pct = 0;
    int                  out_stall_pct = 0;
    bit                  hold_req = 1'b0;

    logic [7:0] addr_plan [PHASES] = '{8'h02, 8'h00, 8'hFF, 8'hA5, 8'h3C, 8'h02};
    logic       rx_plan   [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    logic       tx_plan   [PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

    multidrop_uart_slave_block_transfer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #3_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        errors++;
    endtask

    function automatic void emit_reply(input logic kind, input logic [7:0] b, input logic lst);
        mdus_pkg::t_out_item r;
        r.kind      = kind;
        r.data_byte = b;
        r.last      = lst;
        step_q.push_back(r);
    endfunction

    // whole transmit block followed by its additive checksum
    function automatic void emit_tx_block();
        logic [7:0] sum;
        sum = 8'h00;
        for (int i = 0; i < mdus_pkg::BLOCK_BYTES; i++) begin
            sum += tx_store[i % mdus_pkg::STORE_DEPTH];
            emit_reply(1'b0, tx_store[i % mdus_pkg::STORE_DEPTH], 1'b0);
        end
        emit_reply(1'b0, sum, 1'b1);
    endfunction

    function automatic void slave_step(input mdus_pkg::t_in_item it);
        step_q.delete();
        case (it.op)
            mdus_pkg::OP_LOAD: tx_store[it.entry_index] = it.entry_value;
            mdus_pkg::OP_READ: emit_reply(1'b1, rx_store[it.entry_index], 1'b1);
            mdus_pkg::OP_FRAME: begin
                case (link)
                    LS_CMD: begin
                        if (it.ninth_bit) begin
                            link = LS_IDLE;
                        end else if (it.frame_byte == mdus_pkg::CMD_RECEIVE) begin
                            link = LS_RX_GO;
                            emit_reply(1'b0, cfg_rx_rdy ? mdus_pkg::CMD_RECEIVE
                                                        : mdus_pkg::ST_NOT_READY, 1'b1);
                        end else if (it.frame_byte == mdus_pkg::CMD_SEND) begin
                            link = LS_TX_GO;
                            emit_reply(1'b0, cfg_tx_rdy ? mdus_pkg::CMD_SEND
                                                        : mdus_pkg::ST_NOT_READY, 1'b1);
                        end else begin
                            link = LS_IDLE;
                            emit_reply(1'b0, mdus_pkg::ST_ERROR, 1'b1);
                        end
                    end
                    LS_RX_GO: begin
                        if (it.ninth_bit) begin
                            link = LS_IDLE;
                        end else begin
                            cfg_rx_rdy = 1'b0;
                            blk_count  = '0;
                            blk_sum    = 8'h00;
                            link       = LS_RX_DATA;
                        end
                    end
                    LS_RX_DATA: begin
                        rx_store[blk_count[mdus_pkg::STORE_AW-1:0]]   = it.frame_byte;
                        rx_written[blk_count[mdus_pkg::STORE_AW-1:0]] = 1'b1;
                        blk_sum += it.frame_byte;
                        blk_count++;
                        if (blk_count >= mdus_pkg::BLOCK_BYTES) link = LS_RX_SUM;
                    end
                    LS_RX_SUM: begin
                        if (it.frame_byte == blk_sum) begin
                            link = LS_IDLE;
                            emit_reply(1'b0, mdus_pkg::ST_GOOD, 1'b1);
                        end else begin
                            blk_count = '0;
                            blk_sum   = 8'h00;
                            link      = LS_RX_DATA;
                            emit_reply(1'b0, mdus_pkg::ST_BAD, 1'b1);
                        end
                    end
                    LS_TX_GO: begin
                        if (it.ninth_bit) begin
                            link = LS_IDLE;
                        end else begin
                            cfg_tx_rdy = 1'b0;
                            link       = LS_TX_ACK;
                            emit_tx_block();
                        end
                    end
                    LS_TX_ACK: begin
                        if (it.frame_byte == ACK_DONE) link = LS_IDLE;
                        else emit_tx_block();
                    end
                    default: begin
                        link = LS_IDLE;
                        if (it.ninth_bit && it.frame_byte == cfg_addr) begin
                            link = LS_CMD;
                            emit_reply(1'b0, cfg_addr, 1'b1);
                        end
                    end
                endcase
            end
            default: ;
        endcase
    endfunction

    function automatic mdus_pkg::t_in_item frame_item(input logic [7:0] b, input logic nb);
        mdus_pkg::t_in_item it;
        it.op          = mdus_pkg::OP_FRAME;
        it.frame_byte  = b;
        it.ninth_bit   = nb;
        it.entry_index = 4'($urandom_range(15));
        it.entry_value = 8'($urandom_range(255));
        return it;
    endfunction

    // load or read with random fields; reads only hit entries already received
    function automatic mdus_pkg::t_in_item store_item(input logic [1:0] op);
        mdus_pkg::t_in_item it;
        it = frame_item(8'($urandom_range(255)), 1'($urandom_range(1)));
        it.op = op;
        if (op == mdus_pkg::OP_READ) begin
            if (rx_written == '0) it.op = mdus_pkg::OP_LOAD;
            else while (!rx_written[it.entry_index]) it.entry_index = 4'($urandom_range(15));
        end
        return it;
    endfunction

    function automatic void add_row(input mdus_pkg::t_in_item it, input bit typed,
                                    input logic [7:0] reply);
        t_row r;
        r.item  = it;
        r.typed = typed;
        r.reply = reply;
        plan.push_back(r);
    endfunction

    // caller sits at a falling edge; returns at the falling edge after the transaction
    task automatic offer(input mdus_pkg::t_in_item it, input bit typed = 1'b0,
                         input logic [7:0] reply = 8'h00);
        mdus_pkg::t_out_item r;
        t_link_state         prev;
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        prev = link;
        slave_step(it);
        if (typed) begin
            r.kind      = 1'b0;
            r.data_byte = reply;
            r.last      = 1'b1;
            reply_q.push_back(r);
        end else begin
            foreach (step_q[i]) reply_q.push_back(step_q[i]);
        end
        if (!(it.op == OP_UNUSED ||
              (it.op == mdus_pkg::OP_FRAME && prev == LS_IDLE && step_q.size() == 0)))
            items_sent++;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic drain_replies(input int settle);
        in_valid <= 1'b0;
        @(negedge clk);
        while (reply_q.size() != 0) @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            mdus_pkg::REG_SLAVE_ADDR: cfg_addr   = value[7:0];
            mdus_pkg::REG_RX_READY:   cfg_rx_rdy = value[0];
            mdus_pkg::REG_TX_READY:   cfg_tx_rdy = value[0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // an occasional store op slipped in between frames
    task automatic send_frame(input logic [7:0] b, input logic nb);
        if ($urandom_range(9) == 0)
            offer(store_item($urandom_range(1) ? mdus_pkg::OP_LOAD : mdus_pkg::OP_READ));
        offer(frame_item(b, nb));
    endtask

    task automatic run_sequence(input t_seq_kind kind);
        mdus_pkg::t_in_item it;
        logic [7:0]         sum;
        logic [7:0]         b;
        int                 pick;
        int                 tries;
        bit                 bad;
        pick = $urandom_range(5);
        // close any open exchange so the sequence starts from idle (single-item noise skips this)
        if (kind != SEQ_NOISE || pick >= 4) begin
            while (link != LS_IDLE) begin
                case (link)
                    LS_RX_DATA: offer(frame_item(8'($urandom_range(255)), 1'($urandom_range(1))));
                    LS_RX_SUM:  offer(frame_item(blk_sum, 1'($urandom_range(1))));
                    LS_TX_ACK:  offer(frame_item(ACK_DONE, 1'($urandom_range(1))));
                    default:    offer(frame_item(8'($urandom_range(255)), 1'b1));
                endcase
            end
        end
        case (kind)
            SEQ_RECEIVE: begin
                send_frame(cfg_addr, 1'b1);
                send_frame(mdus_pkg::CMD_RECEIVE, 1'b0);
                send_frame(8'($urandom_range(255)), 1'b0);
                tries = 0;
                do begin
                    sum = 8'h00;
                    for (int k = 0; k < mdus_pkg::BLOCK_BYTES; k++) begin
                        b = 8'($urandom_range(255));
                        sum += b;
                        send_frame(b, 1'($urandom_range(1)));
                    end
                    bad = (tries < 2) && ($urandom_range(3) == 0);
                    send_frame(bad ? sum + 8'($urandom_range(1, 255)) : sum,
                               1'($urandom_range(1)));
                    tries++;
                end while (bad);
            end
            SEQ_SEND: begin
                send_frame(cfg_addr, 1'b1);
                send_frame(mdus_pkg::CMD_SEND, 1'b0);
                send_frame(8'($urandom_range(255)), 1'b0);
                repeat ($urandom_range(2)) send_frame(8'($urandom_range(1, 255)),
                                                      1'($urandom_range(1)));
                send_frame(ACK_DONE, 1'($urandom_range(1)));
            end
            default: begin
                case (pick)
                    0: offer(frame_item($urandom_range(2) == 0 ? cfg_addr
                                                               : 8'($urandom_range(255)),
                                        1'($urandom_range(1))));
                    1: offer(store_item(mdus_pkg::OP_LOAD));
                    2: offer(store_item(mdus_pkg::OP_READ));
                    3: begin
                        it = store_item(mdus_pkg::OP_LOAD);
                        it.op = OP_UNUSED;
                        offer(it);
                    end
                    4: begin
                        b = 8'($urandom_range(255));
                        if (b == mdus_pkg::CMD_RECEIVE || b == mdus_pkg::CMD_SEND)
                            b = mdus_pkg::ST_ERROR;
                        send_frame(cfg_addr, 1'b1);
                        send_frame(b, 1'b0);
                    end
                    default: begin
                        send_frame(cfg_addr, 1'b1);
                        if ($urandom_range(1))
                            send_frame($urandom_range(1) ? mdus_pkg::CMD_RECEIVE
                                                         : mdus_pkg::CMD_SEND, 1'b0);
                        send_frame(8'($urandom_range(255)), 1'b1);
                    end
                endcase
            end
        endcase
    endtask

    // receiver: random stall, or a long hold-off when asked
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < out_stall_pct);
            end
        end
    end

    always @(posedge clk) begin : check_replies
        mdus_pkg::t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (reply_q.size() == 0) begin
                report_mismatch("result with none pending, data_byte", out_item.data_byte, 8'h00);
            end else begin
                want = reply_q.pop_front();
                if (out_item.kind !== want.kind)
                    report_mismatch("kind", 8'(out_item.kind), 8'(want.kind));
                if (out_item.data_byte !== want.data_byte)
                    report_mismatch("data_byte", out_item.data_byte, want.data_byte);
                if (out_item.last !== want.last)
                    report_mismatch("last", 8'(out_item.last), 8'(want.last));
            end
        end
    end

    initial begin : stimulus
        mdus_pkg::t_in_item it;
        int                 goal;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_item    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        cfg_addr   = RESET_SLAVE_ADDR;
        cfg_rx_rdy = 1'b1;
        cfg_tx_rdy = 1'b1;
        link       = LS_IDLE;
        blk_count  = '0;
        blk_sum    = 8'h00;
        rx_written = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed rows, reset register values
        add_row(frame_item(RESET_SLAVE_ADDR, 1'b0), 1'b0, 8'h00);  // data frame while idle
        add_row(frame_item(8'hFF, 1'b1), 1'b0, 8'h00);             // other address
        add_row(frame_item(8'h00, 1'b1), 1'b0, 8'h00);
        add_row(frame_item(RESET_SLAVE_ADDR, 1'b1), 1'b1, RESET_SLAVE_ADDR);
        add_row(frame_item(8'h7E, 1'b0), 1'b1, mdus_pkg::ST_ERROR);
        add_row(frame_item(RESET_SLAVE_ADDR, 1'b1), 1'b1, RESET_SLAVE_ADDR);
        add_row(frame_item(RESET_SLAVE_ADDR, 1'b1), 1'b0, 8'h00);  // abort while awaiting command
        add_row(frame_item(RESET_SLAVE_ADDR, 1'b1), 1'b1, RESET_SLAVE_ADDR);
        add_row(frame_item(mdus_pkg::CMD_RECEIVE, 1'b0), 1'b1, mdus_pkg::CMD_RECEIVE);
        add_row(frame_item(8'hFF, 1'b1), 1'b0, 8'h00);             // abort before receive go
        add_row(frame_item(RESET_SLAVE_ADDR, 1'b1), 1'b1, RESET_SLAVE_ADDR);
        add_row(frame_item(mdus_pkg::CMD_SEND, 1'b0), 1'b1, mdus_pkg::CMD_SEND);
        add_row(frame_item(8'h00, 1'b1), 1'b0, 8'h00);             // abort before send go
        it = store_item(mdus_pkg::OP_LOAD);
        it.entry_index = 4'hF;
        it.entry_value = 8'hFF;
        add_row(it, 1'b0, 8'h00);
        it.entry_index = 4'h0;
        it.entry_value = 8'h00;
        add_row(it, 1'b0, 8'h00);
        it = '1;
        add_row(it, 1'b0, 8'h00);                                  // unknown op
        add_row(frame_item(RESET_SLAVE_ADDR, 1'b1), 1'b1, RESET_SLAVE_ADDR);
        add_row(frame_item(8'h00, 1'b0), 1'b1, mdus_pkg::ST_ERROR);
        add_row(frame_item(RESET_SLAVE_ADDR, 1'b1), 1'b1, RESET_SLAVE_ADDR);
        add_row(frame_item(8'hFF, 1'b0), 1'b1, mdus_pkg::ST_ERROR);
        foreach (plan[i]) offer(plan[i].item, plan[i].typed, plan[i].reply);

        // a block send reads every transmit entry, so fill them all first
        for (int e = 0; e < mdus_pkg::STORE_DEPTH; e++) begin
            it = store_item(mdus_pkg::OP_LOAD);
            it.entry_index = 4'(e);
            offer(it);
        end

        addr_plan[PHASES-1] = 8'($urandom_range(255));
        for (int ph = 0; ph < PHASES; ph++) begin
            drain_replies(SETTLE_CYCLES);
            write_reg(mdus_pkg::REG_SLAVE_ADDR, 32'(addr_plan[ph]));
            write_reg(mdus_pkg::REG_RX_READY, 32'(rx_plan[ph]));
            write_reg(mdus_pkg::REG_TX_READY, 32'(tx_plan[ph]));
            case (ph % 4)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 70; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 70; end
                default: begin in_idle_pct = 23; out_stall_pct = 23; end
            endcase
            // long receiver hold-off while a burst and more frames are offered
            if (ph == 0) begin
                hold_req = 1'b1;
                run_sequence(SEQ_SEND);
                run_sequence(SEQ_SEND);
            end
            goal = plan.size() + (ph + 1) * (ITEM_GOAL - plan.size()) / PHASES;
            while (items_sent < goal) begin
                case ($urandom_range(99) / 35)
                    0: run_sequence(SEQ_RECEIVE);
                    1: run_sequence(SEQ_SEND);
                    default: run_sequence(SEQ_NOISE);
                endcase
            end
        end

        drain_replies(SETTLE_CYCLES);
        if (errors == 0 && reply_q.size() == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/mdus_pkg.sv
rtl/mdus_ram.sv
rtl/mdus_ctrl.sv
rtl/mdus_dp.sv
rtl/multidrop_uart_slave_block_transfer.sv
tb/testbench.sv
